### rtl/core/hrv_pkg.sv
// ----------------------------------------------------------------------------
// hrv_pkg
// Shared types, character codes and keyword tables of the HTTP/1.0 request
// header checker.
// ----------------------------------------------------------------------------
package hrv_pkg;

    localparam int MAX_REQUEST_DEF = 2048;
    localparam int POS_W           = 11;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_METHOD,
        PH_NAME,
        PH_VERSION,
        PH_AFTER_REQ,
        PH_GET_LF,
        PH_HNAME,
        PH_HVALUE,
        PH_VAL_LF,
        PH_HAFTER,
        PH_END_LF
    } t_phase;

    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [3:0] GET_LEN  = 4'd5;
    localparam logic [3:0] POST_LEN = 4'd6;
    localparam logic [3:0] VER_LEN  = 4'd10;
    localparam logic [3:0] CL_LEN   = 4'd15;

    // space, tab, LF, VT, FF, CR
    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    // "GET /" or "POST /"
    function automatic logic [7:0] method_char(input logic post, input logic [3:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (post) begin
            case (idx)
                4'd0:    c = "P";
                4'd1:    c = "O";
                4'd2:    c = "S";
                4'd3:    c = "T";
                4'd4:    c = " ";
                4'd5:    c = "/";
                default: c = 8'h00;
            endcase
        end else begin
            case (idx)
                4'd0:    c = "G";
                4'd1:    c = "E";
                4'd2:    c = "T";
                4'd3:    c = " ";
                4'd4:    c = "/";
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    // "HTTP/1.0" CRLF
    function automatic logic [7:0] ver_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "H";
            4'd1:    c = "T";
            4'd2:    c = "T";
            4'd3:    c = "P";
            4'd4:    c = "/";
            4'd5:    c = "1";
            4'd6:    c = ".";
            4'd7:    c = "0";
            4'd8:    c = CH_CR;
            4'd9:    c = CH_LF;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "Content-Length:"
    function automatic logic [7:0] cl_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### rtl/core/hrv_if.sv
// ----------------------------------------------------------------------------
// hrv_if
// Valid/ready channels of the request checker: request bytes in, verdicts out.
// ----------------------------------------------------------------------------
interface hrv_req_if;
    logic       valid;
    logic       ready;
    logic       first;
    logic [7:0] byte_in;

    modport source (output valid, output first, output byte_in, input ready);
    modport sink   (input valid, input first, input byte_in, output ready);
endinterface

interface hrv_res_if;
    logic                      valid;
    logic                      ready;
    logic                      verdict;
    logic                      method;
    logic [hrv_pkg::POS_W-1:0] name_start;
    logic [hrv_pkg::POS_W-1:0] name_end;
    logic                      has_length;
    logic [hrv_pkg::POS_W-1:0] length_start;
    logic [hrv_pkg::POS_W-1:0] length_end;
    logic                      has_body_start;
    logic [hrv_pkg::POS_W-1:0] body_start;

    modport source (
        output valid, output verdict, output method, output name_start, output name_end,
        output has_length, output length_start, output length_end,
        output has_body_start, output body_start, input ready
    );
    modport sink (
        input valid, input verdict, input method, input name_start, input name_end,
        input has_length, input length_start, input length_end,
        input has_body_start, input body_start, output ready
    );
endinterface

### rtl/core/http_request_validator.sv
// ----------------------------------------------------------------------------
// http_request_validator
// Byte-serial HTTP/1.0 request header checker: one verdict per request with
// method and byte positions of file name, Content-Length value and body.
// ----------------------------------------------------------------------------
//  channel | dir | beat
//  i_req   | in  | first, byte_in      (one request byte)
//  o_res   | out | verdict .. body_start (one verdict per request)
//
//  One byte per cycle. A byte is staged in the input register, is parsed in
//  one pass and its verdict, if any, lands in the result register. i_req
//  stalls only when the staged byte decides a request while the result
//  register holds a beat not yet taken.
//  Synchronous active-low reset clears the pipeline and idles the parser.
// ----------------------------------------------------------------------------
module http_request_validator #(
    parameter int MAX_REQUEST = hrv_pkg::MAX_REQUEST_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hrv_req_if.sink          i_req,
    hrv_res_if.source        o_res
);

    localparam int CNT_W = $clog2(MAX_REQUEST + 1);
    localparam int PW    = hrv_pkg::POS_W;

    typedef struct packed {
        hrv_pkg::t_phase  phase;
        logic [CNT_W-1:0] pos;
        logic             post;
        logic [PW-1:0]    tok;
        logic [3:0]       idx;
        logic             still;
        logic [1:0]       cnt;
        logic             cl_line;
        logic             colon;
        logic [PW-1:0]    fn_s;
        logic [PW-1:0]    fn_e;
        logic [PW-1:0]    lv_s;
        logic [PW-1:0]    lv_e;
    } t_pst;

    typedef struct packed {
        logic          verdict;
        logic          method;
        logic [PW-1:0] name_start;
        logic [PW-1:0] name_end;
        logic          has_length;
        logic [PW-1:0] length_start;
        logic [PW-1:0] length_end;
        logic          has_body_start;
        logic [PW-1:0] body_start;
    } t_res;

    logic       r_in_valid;
    logic       r_in_first;
    logic [7:0] r_in_byte;
    t_pst       r_st, n_st, c_st;
    logic       r_out_valid;
    t_res       r_out, n_out;

    logic w_emit, w_out_free, w_adv, w_in_ready;
    logic w_ok, w_done, w_good, w_body, w_name;
    logic [PW-1:0] w_p11;
    logic [3:0]    w_len;

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_adv      = r_in_valid && (!w_emit || w_out_free);
    assign w_in_ready = !r_in_valid || w_adv;
    assign i_req.ready = w_in_ready;

    always_comb begin
        c_st = r_st;
        if (r_in_first) begin
            c_st       = '0;
            c_st.phase = hrv_pkg::PH_METHOD;
        end
        n_st   = c_st;
        w_ok   = 1'b1;
        w_done = 1'b0;
        w_good = 1'b0;
        w_body = 1'b0;
        w_name = 1'b0;
        w_emit = 1'b0;
        w_p11  = PW'(c_st.pos);
        w_len  = c_st.post ? hrv_pkg::POST_LEN : hrv_pkg::GET_LEN;
        n_out  = '0;

        if (c_st.phase != hrv_pkg::PH_IDLE) begin
            case (c_st.phase)
                hrv_pkg::PH_METHOD: begin
                    if (c_st.pos == '0) begin
                        n_st.idx = 4'd1;
                        if (r_in_byte == hrv_pkg::CH_G) begin
                            n_st.post = 1'b0;
                        end else if (r_in_byte == hrv_pkg::CH_P) begin
                            n_st.post = 1'b1;
                        end else begin
                            w_ok = 1'b0;
                        end
                    end else if (r_in_byte != hrv_pkg::method_char(c_st.post, c_st.idx)) begin
                        w_ok = 1'b0;
                    end else begin
                        n_st.idx = c_st.idx + 4'd1;
                        if (n_st.idx >= w_len) begin
                            n_st.fn_s  = w_p11 + PW'(1);
                            n_st.phase = hrv_pkg::PH_NAME;
                        end
                    end
                end
                hrv_pkg::PH_NAME: begin
                    if (hrv_pkg::is_ws(r_in_byte)) begin
                        if (r_in_byte != hrv_pkg::CH_SPACE) begin
                            w_ok = 1'b0;
                        end else begin
                            n_st.fn_e  = w_p11 - PW'(1);
                            n_st.idx   = 4'd0;
                            n_st.phase = hrv_pkg::PH_VERSION;
                        end
                    end
                end
                hrv_pkg::PH_VERSION: begin
                    if (r_in_byte != hrv_pkg::ver_char(c_st.idx)) begin
                        w_ok = 1'b0;
                    end else begin
                        n_st.idx = c_st.idx + 4'd1;
                        if (n_st.idx >= hrv_pkg::VER_LEN) begin
                            n_st.phase = hrv_pkg::PH_AFTER_REQ;
                        end
                    end
                end
                hrv_pkg::PH_AFTER_REQ: begin
                    if (!c_st.post && r_in_byte == hrv_pkg::CH_CR) begin
                        n_st.phase = hrv_pkg::PH_GET_LF;
                    end else begin
                        n_st.idx   = 4'd0;
                        n_st.still = 1'b1;
                        n_st.colon = 1'b0;
                        n_st.phase = hrv_pkg::PH_HNAME;
                        w_name     = 1'b1;
                    end
                end
                hrv_pkg::PH_GET_LF: begin
                    if (r_in_byte != hrv_pkg::CH_LF) begin
                        w_ok = 1'b0;
                    end else begin
                        w_done = 1'b1;
                        w_good = 1'b1;
                    end
                end
                hrv_pkg::PH_HNAME: begin
                    w_name = 1'b1;
                end
                hrv_pkg::PH_HVALUE: begin
                    if (hrv_pkg::is_ws(r_in_byte)) begin
                        if (r_in_byte != hrv_pkg::CH_CR) begin
                            w_ok = 1'b0;
                        end else begin
                            if (c_st.cl_line) begin
                                n_st.lv_s = c_st.tok;
                                n_st.lv_e = w_p11 - PW'(1);
                            end
                            n_st.phase = hrv_pkg::PH_VAL_LF;
                        end
                    end
                end
                hrv_pkg::PH_VAL_LF: begin
                    if (r_in_byte != hrv_pkg::CH_LF) begin
                        w_ok = 1'b0;
                    end else begin
                        n_st.phase = hrv_pkg::PH_HAFTER;
                    end
                end
                hrv_pkg::PH_HAFTER: begin
                    if (r_in_byte == hrv_pkg::CH_CR) begin
                        n_st.phase = hrv_pkg::PH_END_LF;
                    end else begin
                        n_st.idx   = 4'd0;
                        n_st.still = 1'b1;
                        n_st.colon = 1'b0;
                        n_st.phase = hrv_pkg::PH_HNAME;
                        w_name     = 1'b1;
                    end
                end
                hrv_pkg::PH_END_LF: begin
                    if (r_in_byte != hrv_pkg::CH_LF) begin
                        w_ok = 1'b0;
                    end else begin
                        w_done = 1'b1;
                        w_good = !(c_st.post && c_st.cnt != 2'd1);
                        w_body = 1'b1;
                    end
                end
                default: begin
                    w_ok = 1'b0;
                end
            endcase

            // header name byte
            if (w_name) begin
                if (!hrv_pkg::is_ws(r_in_byte)) begin
                    if (n_st.idx < hrv_pkg::CL_LEN && r_in_byte == hrv_pkg::cl_char(n_st.idx)) begin
                        n_st.idx = n_st.idx + 4'd1;
                    end else begin
                        n_st.still = 1'b0;
                    end
                    n_st.colon = (r_in_byte == hrv_pkg::CH_COLON);
                end else if (r_in_byte != hrv_pkg::CH_SPACE || !n_st.colon) begin
                    w_ok = 1'b0;
                end else begin
                    n_st.cl_line = n_st.still && (n_st.idx == hrv_pkg::CL_LEN);
                    if (n_st.cl_line && n_st.cnt != 2'd2) begin
                        n_st.cnt = n_st.cnt + 2'd1;
                    end
                    n_st.tok   = w_p11 + PW'(1);
                    n_st.phase = hrv_pkg::PH_HVALUE;
                end
            end

            n_st.pos = c_st.pos + CNT_W'(1);
            if (w_done || !w_ok || c_st.pos == CNT_W'(MAX_REQUEST - 1)) begin
                w_emit     = 1'b1;
                n_st.phase = hrv_pkg::PH_IDLE;
            end

            if (w_done && w_good) begin
                n_out.method     = n_st.post;
                n_out.name_start = n_st.fn_s;
                n_out.name_end   = n_st.fn_e;
                if (n_st.cnt != 2'd0) begin
                    n_out.has_length   = 1'b1;
                    n_out.length_start = n_st.lv_s;
                    n_out.length_end   = n_st.lv_e;
                end
                if (w_body) begin
                    n_out.has_body_start = 1'b1;
                    n_out.body_start     = w_p11 + PW'(1);
                end
            end else begin
                n_out.verdict = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_req.valid;
        end
        if (i_req.valid && w_in_ready) begin
            r_in_first <= i_req.first;
            r_in_byte  <= i_req.byte_in;
        end
    end

    // all-zero state is the idle phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (w_adv) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv && w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.verdict        = r_out.verdict;
    assign o_res.method         = r_out.method;
    assign o_res.name_start     = r_out.name_start;
    assign o_res.name_end       = r_out.name_end;
    assign o_res.has_length     = r_out.has_length;
    assign o_res.length_start   = r_out.length_start;
    assign o_res.length_end     = r_out.length_end;
    assign o_res.has_body_start = r_out.has_body_start;
    assign o_res.body_start     = r_out.body_start;

`ifndef SYNTHESIS
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.verdict) |-> (!o_res.method && !o_res.has_length &&
            !o_res.has_body_start && o_res.name_start == '0 && o_res.name_end == '0 &&
            o_res.body_start == '0))
        else $error("rejected beat carries nonzero fields");

    a_post_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.verdict && o_res.method) |->
            (o_res.has_length && o_res.has_body_start))
        else $error("accepted POST without length or body");

    a_idle_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit) |=> (r_st.phase == hrv_pkg::PH_IDLE))
        else $error("parser not idle after verdict");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_in_valid && r_out_valid && w_emit && !o_res.ready))
        else $error("input stalled without a blocked verdict");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HTTP/1.0 request checker. Request bytes go in
// through a bursty sender; a behavioral parser predicts each verdict beat and
// a scoreboard compares every field of the results drained by a stalling
// receiver. Directed requests cover the header forms and corner cases, then
// random well-formed, damaged and noise requests follow.
// ----------------------------------------------------------------------------
module tb;
    import hrv_pkg::*;

    localparam int RANDOM_BEATS = 1500;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE       = 6;

    localparam logic [8*5-1:0]  GET_WORD  = "GET /";
    localparam logic [8*6-1:0]  POST_WORD = "POST /";
    localparam logic [8*10-1:0] VER_WORD  = {"HTTP/1.0", CH_CR, CH_LF};
    localparam logic [8*15-1:0] CL_WORD   = "Content-Length:";

    typedef struct packed {
        logic             verdict;
        logic             method;
        logic [POS_W-1:0] name_start;
        logic [POS_W-1:0] name_end;
        logic             has_length;
        logic [POS_W-1:0] length_start;
        logic [POS_W-1:0] length_end;
        logic             has_body_start;
        logic [POS_W-1:0] body_start;
    } verdict_t;

    typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_DENSE} sink_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    hrv_req_if req_if ();
    hrv_res_if res_if ();

    http_request_validator dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // parser shadow state
    t_phase ph         = PH_IDLE;
    int     at_pos     = 0;
    int     tok_start  = 0;
    int     fn_start   = 0;
    int     fn_end     = 0;
    int     cl_start   = 0;
    int     cl_end     = 0;
    int     match_idx  = 0;
    int     cl_count   = 0;
    bit     post_req   = 1'b0;
    bit     match_ok   = 1'b0;
    bit     line_is_cl = 1'b0;
    bit     prev_colon = 1'b0;
    bit     decided    = 1'b1;

    verdict_t   pending_verdicts[$];
    logic [7:0] req_bytes[$];

    int fail_count    = 0;
    int stall_cycles  = 0;
    int bytes_in      = 0;
    int requests_sent = 0;
    int accepted_cnt  = 0;
    int rejected_cnt  = 0;
    int hold_requests = 0;
    int burst_left    = 0;
    bit gaps_on       = 1'b1;

    function automatic bit is_blank(logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic void clear_parser();
        ph = PH_IDLE;
        at_pos = 0;
        tok_start = 0;
        fn_start = 0;
        fn_end = 0;
        cl_start = 0;
        cl_end = 0;
        match_idx = 0;
        cl_count = 0;
        post_req = 1'b0;
        match_ok = 1'b0;
        line_is_cl = 1'b0;
        prev_colon = 1'b0;
        decided = 1'b1;
    endfunction

    function automatic verdict_t close_request(bit ok, bit with_body, int body);
        verdict_t v;
        v = '0;
        decided = 1'b1;
        ph = PH_IDLE;
        if (!ok) begin
            v.verdict = 1'b1;
            return v;
        end
        v.method = post_req;
        v.name_start = fn_start[POS_W-1:0];
        v.name_end = fn_end[POS_W-1:0];
        if (cl_count != 0) begin
            v.has_length = 1'b1;
            v.length_start = cl_start[POS_W-1:0];
            v.length_end = cl_end[POS_W-1:0];
        end
        if (with_body) begin
            v.has_body_start = 1'b1;
            v.body_start = body[POS_W-1:0];
        end
        return v;
    endfunction

    function automatic bit header_name_byte(logic [7:0] b, int p);
        if (!is_blank(b)) begin
            if (match_idx < CL_LEN && b == CL_WORD[8*(14-match_idx) +: 8]) begin
                match_idx++;
            end else begin
                match_ok = 1'b0;
            end
            prev_colon = (b == CH_COLON);
            return 1'b1;
        end
        if (b != CH_SPACE || !prev_colon) return 1'b0;
        line_is_cl = match_ok && (match_idx == CL_LEN);
        if (line_is_cl && cl_count < 2) cl_count++;
        tok_start = p + 1;
        ph = PH_HVALUE;
        return 1'b1;
    endfunction

    function automatic bit begin_header(logic [7:0] b, int p);
        match_idx = 0;
        match_ok = 1'b1;
        prev_colon = 1'b0;
        ph = PH_HNAME;
        return header_name_byte(b, p);
    endfunction

    // one accepted request byte; returns 1 when it decides the request
    function automatic bit parse_step(input logic f, input logic [7:0] b,
                                      output verdict_t v);
        int         p;
        bit         ok;
        logic [7:0] want;
        v = '0;
        ok = 1'b1;
        if (f) begin
            clear_parser();
            decided = 1'b0;
            ph = PH_METHOD;
        end
        if (decided) return 1'b0;
        p = at_pos;
        case (ph)
            PH_METHOD: begin
                if (p == 0) begin
                    if (b == CH_G) post_req = 1'b0;
                    else if (b == CH_P) post_req = 1'b1;
                    else ok = 1'b0;
                    match_idx = 1;
                end else begin
                    want = post_req ? POST_WORD[8*(5-match_idx) +: 8]
                                    : GET_WORD[8*(4-match_idx) +: 8];
                    if (b != want) begin
                        ok = 1'b0;
                    end else begin
                        match_idx++;
                        if (match_idx >= (post_req ? POST_LEN : GET_LEN)) begin
                            fn_start = p + 1;
                            ph = PH_NAME;
                        end
                    end
                end
            end
            PH_NAME: begin
                if (is_blank(b)) begin
                    if (b != CH_SPACE) begin
                        ok = 1'b0;
                    end else begin
                        fn_end = p - 1;
                        match_idx = 0;
                        ph = PH_VERSION;
                    end
                end
            end
            PH_VERSION: begin
                if (b != VER_WORD[8*(9-match_idx) +: 8]) begin
                    ok = 1'b0;
                end else begin
                    match_idx++;
                    if (match_idx >= VER_LEN) ph = PH_AFTER_REQ;
                end
            end
            PH_AFTER_REQ: begin
                if (!post_req && b == CH_CR) ph = PH_GET_LF;
                else ok = begin_header(b, p);
            end
            PH_GET_LF: begin
                if (b == CH_LF) begin
                    at_pos = p + 1;
                    v = close_request(1'b1, 1'b0, 0);
                    return 1'b1;
                end
                ok = 1'b0;
            end
            PH_HNAME: ok = header_name_byte(b, p);
            PH_HVALUE: begin
                if (is_blank(b)) begin
                    if (b != CH_CR) begin
                        ok = 1'b0;
                    end else begin
                        if (line_is_cl) begin
                            cl_start = tok_start;
                            cl_end = p - 1;
                        end
                        ph = PH_VAL_LF;
                    end
                end
            end
            PH_VAL_LF: begin
                if (b != CH_LF) ok = 1'b0;
                else ph = PH_HAFTER;
            end
            PH_HAFTER: begin
                if (b == CH_CR) ph = PH_END_LF;
                else ok = begin_header(b, p);
            end
            PH_END_LF: begin
                if (b == CH_LF) begin
                    at_pos = p + 1;
                    v = close_request(!(post_req && cl_count != 1), 1'b1, p + 1);
                    return 1'b1;
                end
                ok = 1'b0;
            end
            default: ok = 1'b0;
        endcase
        at_pos = p + 1;
        if (!ok || at_pos >= MAX_REQUEST_DEF) begin
            v = close_request(1'b0, 1'b0, 0);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic string show_verdict(verdict_t v);
        return $sformatf("rej=%0d post=%0d name=%0d..%0d len=%0d:%0d..%0d body=%0d:%0d",
                         v.verdict, v.method, v.name_start, v.name_end, v.has_length,
                         v.length_start, v.length_end, v.has_body_start, v.body_start);
    endfunction

    // scoreboard: predicts on each request beat, checks each verdict beat
    always @(posedge clk) begin : scoreboard
        verdict_t want;
        verdict_t got;
        string    bad;
        if (rst_n) begin
            if (req_if.valid && req_if.ready) begin
                bytes_in++;
                if (parse_step(req_if.first, req_if.byte_in, want))
                    pending_verdicts.push_back(want);
            end
            if (res_if.valid && res_if.ready) begin
                got.verdict        = res_if.verdict;
                got.method         = res_if.method;
                got.name_start     = res_if.name_start;
                got.name_end       = res_if.name_end;
                got.has_length     = res_if.has_length;
                got.length_start   = res_if.length_start;
                got.length_end     = res_if.length_end;
                got.has_body_start = res_if.has_body_start;
                got.body_start     = res_if.body_start;
                if (pending_verdicts.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected verdict beat %s", $time, show_verdict(got));
                end else begin
                    want = pending_verdicts.pop_front();
                    bad = "";
                    if (got.verdict !== want.verdict) bad = {bad, " verdict"};
                    if (got.method !== want.method) bad = {bad, " method"};
                    if (got.name_start !== want.name_start) bad = {bad, " name_start"};
                    if (got.name_end !== want.name_end) bad = {bad, " name_end"};
                    if (got.has_length !== want.has_length) bad = {bad, " has_length"};
                    if (got.length_start !== want.length_start) bad = {bad, " length_start"};
                    if (got.length_end !== want.length_end) bad = {bad, " length_end"};
                    if (got.has_body_start !== want.has_body_start)
                        bad = {bad, " has_body_start"};
                    if (got.body_start !== want.body_start) bad = {bad, " body_start"};
                    if (bad != "") begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: verdict mismatch on%s", $time, bad);
                            $display("  expected %s", show_verdict(want));
                            $display("  actual   %s", show_verdict(got));
                        end
                    end else if (got.verdict) begin
                        rejected_cnt++;
                    end else begin
                        accepted_cnt++;
                    end
                end
            end
        end
        stall_cycles <= ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                        ? 0 : stall_cycles + 1;
    end

    // verdict receiver: stall patterns plus a long hold-off on request
    initial begin : verdict_sink
        int         run_left;
        int         hold_left;
        int         holds_served;
        sink_mode_t mode;
        run_left = 0;
        hold_left = 0;
        holds_served = 0;
        mode = SINK_OPEN;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    mode = sink_mode_t'($urandom_range(0, 3));
                    run_left = $urandom_range(20, 200);
                end
                run_left--;
                case (mode)
                    SINK_OPEN:   res_if.ready <= 1'b1;
                    SINK_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
                    default:     res_if.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        @(posedge clk);
        while (stall_cycles < STALL_LIMIT) @(posedge clk);
        $display("no beat moved for %0d cycles", STALL_LIMIT);
        $display("http_request_validator verification failed");
        $finish;
    end

    task automatic send_byte(input logic f, input logic [7:0] b);
        int gap;
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = $urandom_range(1, 6);
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left--;
        end
        req_if.valid   <= 1'b1;
        req_if.first   <= f;
        req_if.byte_in <= b;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
    endtask

    task automatic idle_req();
        req_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_request();
        for (int i = 0; i < req_bytes.size(); i++) send_byte(i == 0, req_bytes[i]);
        requests_sent++;
    endtask

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
    endfunction

    function automatic void push_fill(input logic [7:0] c, input int n);
        repeat (n) req_bytes.push_back(c);
    endfunction

    task automatic send_text(input string s);
        req_bytes.delete();
        push_text(s);
        send_request();
    endtask

    function automatic logic [7:0] token_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (is_blank(c)) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic void push_header_line(input bit as_length);
        int         k;
        int         flip;
        logic [7:0] c;
        if (as_length) begin
            push_text("Content-Length:");
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    k = $urandom_range(1, CL_LEN - 2);
                    for (int j = 0; j < k; j++) req_bytes.push_back(CL_WORD[8*(14-j) +: 8]);
                    req_bytes.push_back(CH_COLON);
                end
                1: begin
                    flip = $urandom_range(0, CL_LEN - 2);
                    for (int j = 0; j < CL_LEN; j++) begin
                        c = CL_WORD[8*(14-j) +: 8];
                        if (j == flip) c = c ^ 8'h20;
                        req_bytes.push_back(c);
                    end
                end
                2: begin
                    push_text("Content-Length:");
                    repeat ($urandom_range(1, 3)) req_bytes.push_back(token_char());
                    req_bytes.push_back(CH_COLON);
                end
                default: begin
                    repeat ($urandom_range(1, 5)) req_bytes.push_back(token_char());
                    req_bytes.push_back(CH_COLON);
                end
            endcase
        end
        req_bytes.push_back(CH_SPACE);
        repeat ($urandom_range(0, 5))
            req_bytes.push_back(as_length ? 8'("0" + $urandom_range(0, 9)) : token_char());
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
    endfunction

    function automatic void build_random_request();
        bit post;
        int n_hdr;
        int cl_slot;
        req_bytes.delete();
        post = 1'($urandom_range(0, 1));
        if (post) push_text("POST /");
        else push_text("GET /");
        repeat ($urandom_range(0, 8)) req_bytes.push_back(token_char());
        push_text(" HTTP/1.0\015\012");
        n_hdr = $urandom_range(0, 3);
        if (post && n_hdr == 0 && $urandom_range(0, 3) != 0) n_hdr = 1;
        cl_slot = -1;
        if (n_hdr > 0 && $urandom_range(0, 9) < (post ? 9 : 3))
            cl_slot = $urandom_range(0, n_hdr - 1);
        for (int i = 0; i < n_hdr; i++)
            push_header_line(i == cl_slot || $urandom_range(0, 9) == 0);
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
    endfunction

    task automatic test_stray_bytes();
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, CH_G);
        send_text("GET / HTTP/1.0\015\012\015\012");
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h00);
    endtask

    task automatic test_request_forms();
        send_text({"GET /index.html HTTP/1.0\015\012", "Host: x\015\012\015\012"});
        send_text({"POST /form HTTP/1.0\015\012", "Content-Length: 12\015\012\015\012"});
        send_text({"POST /f HTTP/1.0\015\012Host: h\015\012",
                   "Content-Length: 7\015\012Accept: a\015\012\015\012"});
        send_text({"GET /a HTTP/1.0\015\012Content-Length: 1\015\012",
                   "Content-Length: 22\015\012\015\012"});
        send_text({"GET /\377\200 HTTP/1.0\015\012", "Content-Length: \015\012\015\012"});
        send_text({"GET / HTTP/1.0\015\012", "content-length: 5\015\012\015\012"});
        send_text({"GET /q HTTP/1.0\015\012", "X:v: a\015\012\015\012"});
    endtask

    task automatic test_malformed();
        send_text({"POST /a HTTP/1.0\015\012", "Host: h\015\012\015\012"});
        send_text("POST /a HTTP/1.0\015\012\015\012");
        send_text({"POST /a HTTP/1.0\015\012Content-Length: 1\015\012",
                   "Content-Length: 22\015\012\015\012"});
        send_text("PUT / HTTP/1.0\015\012\015\012");
        send_text("\377ET / HTTP/1.0\015\012\015\012");
        // a NUL byte cannot live in a string, so it goes in as a raw byte
        req_bytes.delete();
        req_bytes.push_back(8'h00);
        push_text("ET / HTTP/1.0\015\012\015\012");
        send_request();
        send_text("GET a HTTP/1.0\015\012\015\012");
        send_text("GET /a\011HTTP/1.0\015\012\015\012");
        send_text("GET /a HTTP/1.1\015\012\015\012");
        send_text({"GET /a HTTP/1.0\015\012", "X:  v\015\012\015\012"});
        send_text({"GET /a HTTP/1.0\015\012", "X : v\015\012\015\012"});
        send_text({"GET /a HTTP/1.0\015\012", "X: v\015\015\012"});
        send_text("GET /ab");
        send_text("GET /cd HTTP/1.0\015\012\015\012");
    endtask

    // 2048-byte requests: limit reject, body position wrap, late request line end
    task automatic test_buffer_limit();
        gaps_on = 1'b0;
        req_bytes.delete();
        push_text("GET /");
        push_fill("a", MAX_REQUEST_DEF - 5);
        send_request();
        req_bytes.delete();
        push_text("GET /");
        push_fill("b", 1000);
        push_text(" HTTP/1.0\015\012A: ");
        push_fill("c", MAX_REQUEST_DEF - 1023);
        push_text("\015\012\015\012");
        send_request();
        req_bytes.delete();
        push_text("GET /");
        push_fill("d", MAX_REQUEST_DEF - 18);
        push_text(" HTTP/1.0\015\012\015\012");
        send_request();
        gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_requests <= hold_requests + 1;
        repeat (8) send_text("GET / HTTP/1.0\015\012\015\012");
        idle_req();
        wait_drained();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int sent;
        int sel;
        int keep;
        int idx;
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                req_bytes.delete();
                repeat ($urandom_range(1, 30)) req_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                build_random_request();
                if (sel < 20) begin
                    idx = $urandom_range(0, req_bytes.size() - 1);
                    if ($urandom_range(0, 1))
                        req_bytes[idx] = 8'($urandom_range(0, 255));
                    else if ($urandom_range(0, 1))
                        req_bytes[idx] = CH_SPACE;
                    else
                        req_bytes[idx] = 8'($urandom_range(CH_TAB, CH_CR));
                end else if (sel < 25) begin
                    keep = $urandom_range(1, req_bytes.size() - 1);
                    while (req_bytes.size() > keep) void'(req_bytes.pop_back());
                end
            end
            sent += req_bytes.size();
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) req_bytes.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
            send_request();
        end
    endtask

    initial begin
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.first   <= 1'b0;
        req_if.byte_in <= 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_stray_bytes();
        test_request_forms();
        test_malformed();
        test_buffer_limit();
        test_backpressure();
        test_random_traffic();
        idle_req();
        wait_drained();

        $display("%0d requests in %0d byte beats; %0d verdicts accepted, %0d rejected",
                 requests_sent, bytes_in, accepted_cnt, rejected_cnt);
        $display("covered header forms, malformed input, 2048-byte limit and wrap, "
                 , "result hold-off and random damaged traffic");
        if (fail_count == 0 && pending_verdicts.size() == 0) begin
            $display("http_request_validator verification clean");
        end else begin
            $display("%0d mismatches, %0d verdicts never arrived",
                     fail_count, pending_verdicts.size());
            $display("http_request_validator verification failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/hrv_pkg.sv
rtl/core/hrv_if.sv
rtl/core/http_request_validator.sv
tb/sv/tb.sv
